@@ design/wvm_pkg.sv @@
// wvm_pkg: shared types and constants for the wavetable voice mixer
// holds func codes, sequencer states and the note-rate rom
// no dependencies
`default_nettype none
package wvm_pkg;

  localparam int VOICE_LIMIT = 16;
  localparam int IDX_W = (VOICE_LIMIT > 1) ? $clog2(VOICE_LIMIT) : 1;
  localparam int CNT_W = $clog2(VOICE_LIMIT + 1);
  localparam int PHASE_SHIFT = 23;
  localparam int WAVE_BITS = 9;
  localparam int QUOT_BITS = 13;
  localparam int PROD_W = 29;
  localparam logic [15:0] RELEASE_RESET = 16'd2205;
  localparam logic [7:0] DEAD_ID = 8'hff;
  localparam logic [6:0] NOTE_MAX = 7'd127;

  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_NOTE_ON  = 3'd1,
    FN_NOTE_OFF = 3'd2,
    FN_FIRE     = 3'd3,
    FN_REL_ALL  = 3'd4,
    FN_SILENCE  = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAIM,
    ST_SWEEP,
    ST_TICK,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  localparam logic [31:0] RATE_ROM [128] = '{
    32'd2125742,32'd2252146,32'd2386065,32'd2527948,32'd2678268,32'd2837526,32'd3006254,
    32'd3185015,32'd3374406,32'd3575058,32'd3787642,32'd4012867,32'd4251485,
    32'd4504291,32'd4772130,32'd5055896,32'd5356535,32'd5675051,32'd6012507,32'd6370030,
    32'd6748811,32'd7150117,32'd7575285,32'd8025735,32'd8502970,32'd9008582,
    32'd9544261,32'd10111792,32'd10713070,32'd11350103,32'd12025015,32'd12740059,
    32'd13497623,32'd14300233,32'd15150569,32'd16051469,32'd17005939,32'd18017165,
    32'd19088521,32'd20223584,32'd21426141,32'd22700205,32'd24050030,32'd25480119,
    32'd26995246,32'd28600467,32'd30301139,32'd32102938,32'd34011878,32'd36034330,
    32'd38177043,32'd40447168,32'd42852281,32'd45400411,32'd48100060,32'd50960238,
    32'd53990491,32'd57200933,32'd60602276,32'd64205876,32'd68023757,32'd72068660,
    32'd76354085,32'd80894335,32'd85704563,32'd90800821,32'd96200119,32'd101920476,
    32'd107980983,32'd114401866,32'd121204555,32'd128411753,32'd136047513,
    32'd144137319,32'd152708170,32'd161788671,32'd171409126,32'd181601643,32'd192400238,
    32'd203840952,32'd215961966,32'd228803732,32'd242409110,32'd256823506,
    32'd272095026,32'd288274639,32'd305416341,32'd323577341,32'd342818251,32'd363203285,
    32'd384800477,32'd407681904,32'd431923931,32'd457607465,32'd484818220,
    32'd513647012,32'd544190053,32'd576549277,32'd610832681,32'd647154683,32'd685636503,
    32'd726406571,32'd769600953,32'd815363807,32'd863847862,32'd915214929,
    32'd969636441,32'd1027294024,32'd1088380105,32'd1153098554,32'd1221665363,
    32'd1294309365,32'd1371273005,32'd1452813141,32'd1539201906,32'd1630727614,
    32'd1727695724,32'd1830429858,32'd1939272882,32'd2054588048,32'd2176760211,
    32'd2306197109,32'd2443330725,32'd2588618730,32'd2742546010,32'd2905626283,
    32'd3078403812,32'd3261455229
  };

endpackage
`default_nettype wire

@@ design/wavetable_voice_mixer.sv @@
// wavetable_voice_mixer: polyphonic wavetable voice table and sample mixer
// one sequencer walks the voice table with a shared multiplier and divider
// depends on wvm_pkg
//
//  channel   signals                               direction  transaction
//  in        in_valid/in_ready func channel note   into       one event
//            lifetime
//  cfg       cfg_valid/cfg_ready cfg_data          into       release_length write
//  out       out_valid/out_ready sample            out of     one mixed sample per tick
//
// silence-all completes in the idle state; note-on and fire-forget do a linear
// search of the voices in use for a free slot; note-off and release-all sweep
// every voice in use; a tick walks every voice in use, and a voice inside its
// release ramp also passes through a multiply step, a load step, 13 restoring
// divide steps and a writeback step.
// reset: synchronous, clears the voice valid flags, the in-use count and
// release_length back to 2205; no clearing pass is needed.
// stalls: a finished tick waits in its last state until the output register is
// free; the output register holds a sample while the next event is taken.
`default_nettype none
module wavetable_voice_mixer
  import wvm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  func,
  input  wire logic [3:0]  channel,
  input  wire logic [7:0]  note,
  input  wire logic [15:0] lifetime,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] sample
);

  // voice table, one flop row per voice
  logic              voice_active  [VOICE_LIMIT];
  logic [7:0]        voice_channel [VOICE_LIMIT];
  logic [7:0]        voice_note    [VOICE_LIMIT];
  logic [31:0]       voice_phase   [VOICE_LIMIT];
  logic [31:0]       voice_step    [VOICE_LIMIT];
  logic [15:0]       voice_life    [VOICE_LIMIT];
  logic [CNT_W-1:0]  voices_in_use;

  logic [15:0]       release_length;
  state_t            state, state_next;

  // latched event
  logic [2:0]        ev_func;
  logic [3:0]        ev_channel;
  logic [7:0]        ev_note;
  logic [15:0]       ev_life;

  // sequencer and datapath registers
  logic [CNT_W-1:0]  idx;
  logic [15:0]       sum;
  logic              w_neg;
  logic [12:0]       w_mag;
  logic [15:0]       life_cur;
  logic [PROD_W-1:0] prod;
  logic [15:0]       rem;
  logic [QUOT_BITS-1:0] quot;
  logic [3:0]        div_cnt;

  logic [IDX_W-1:0]  slot;
  logic              in_range;
  logic              in_fire;

  // wave sample of the voice under the sequencer
  logic [WAVE_BITS-1:0] wave_k;
  logic [WAVE_BITS-1:0] wave_t;
  logic [22:0]       wave_m;
  logic signed [14:0] wave_s;
  logic [15:0]       life_dec;
  logic [16:0]       div_trial;
  logic [16:0]       div_diff;
  logic signed [15:0] scaled;
  logic [6:0]        rate_note;

  assign slot     = idx[IDX_W-1:0];
  assign in_range = (idx < voices_in_use);
  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign wave_k = voice_phase[slot][31:PHASE_SHIFT];
  assign wave_t = WAVE_BITS'(9'd511 - wave_k);
  assign wave_m = 23'(wave_t) * 23'd10000;
  assign wave_s = $signed({1'b0, wave_m[22:9]}) - 15'sd5000;
  assign life_dec = voice_life[slot] - 16'd1;

  assign div_trial = {rem, prod[PROD_W-1]};
  assign div_diff  = div_trial - {1'b0, release_length};
  assign scaled    = w_neg ? -$signed({3'b000, quot}) : $signed({3'b000, quot});

  // clamp to the top rom entry
  assign rate_note = ev_note[7] ? NOTE_MAX : ev_note[6:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (func)
            FN_TICK:                state_next = ST_TICK;
            FN_NOTE_ON, FN_FIRE:    state_next = ST_CLAIM;
            FN_NOTE_OFF, FN_REL_ALL: state_next = ST_SWEEP;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLAIM: begin
        if (!in_range || !voice_active[slot]) state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        if (!in_range) state_next = ST_IDLE;
      end
      ST_TICK: begin
        if (!in_range) begin
          state_next = ST_FINISH;
        end else if (voice_active[slot] && voice_life[slot] != 16'd0 &&
                     life_dec != 16'd0 && life_dec < release_length) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == 4'(QUOT_BITS + 1)) state_next = ST_TICK;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      release_length <= RELEASE_RESET;
      voices_in_use  <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < VOICE_LIMIT; i++) voice_active[i] <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) release_length <= cfg_data;
      if (state == ST_FINISH && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire && func == FN_SILENCE) begin
            voices_in_use <= '0;
            for (int i = 0; i < VOICE_LIMIT; i++) voice_active[i] <= 1'b0;
          end
        end
        ST_CLAIM: begin
          if (in_range) begin
            if (!voice_active[slot]) voice_active[slot] <= 1'b1;
          end else if (voices_in_use < CNT_W'(VOICE_LIMIT)) begin
            voice_active[slot] <= 1'b1;
            voices_in_use <= voices_in_use + CNT_W'(1);
          end
        end
        ST_TICK: begin
          // a fire-forget or released voice whose life runs out is freed
          if (in_range && voice_active[slot] && voice_life[slot] != 16'd0 &&
              life_dec == 16'd0) begin
            voice_active[slot] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and voice fields
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          ev_func    <= func;
          ev_channel <= channel;
          ev_note    <= note;
          ev_life    <= lifetime;
          idx        <= '0;
          sum        <= '0;
        end
      end
      ST_CLAIM: begin
        if (!in_range || !voice_active[slot]) begin
          // slot equals voices_in_use when appending
          if (in_range || voices_in_use < CNT_W'(VOICE_LIMIT)) begin
            voice_phase[slot] <= '0;
            voice_step[slot]  <= RATE_ROM[rate_note];
            if (ev_func == FN_FIRE) begin
              voice_channel[slot] <= DEAD_ID;
              voice_note[slot]    <= DEAD_ID;
              voice_life[slot]    <= ev_life;
            end else begin
              voice_channel[slot] <= {4'b0000, ev_channel};
              voice_note[slot]    <= ev_note;
              voice_life[slot]    <= '0;
            end
          end
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end
      ST_SWEEP: begin
        if (in_range) begin
          if (ev_func == FN_NOTE_OFF) begin
            if (voice_channel[slot] == {4'b0000, ev_channel} && voice_note[slot] == ev_note) begin
              voice_channel[slot] <= DEAD_ID;
              voice_note[slot]    <= DEAD_ID;
              voice_life[slot]    <= release_length;
            end
          end else if (voice_active[slot]) begin
            voice_channel[slot] <= DEAD_ID;
            voice_note[slot]    <= DEAD_ID;
            if (voice_life[slot] == 16'd0 || voice_life[slot] > release_length)
              voice_life[slot] <= release_length;
          end
          idx <= idx + CNT_W'(1);
        end
      end
      ST_TICK: begin
        if (in_range) begin
          if (!voice_active[slot]) begin
            idx <= idx + CNT_W'(1);
          end else if (voice_life[slot] == 16'd0) begin
            // sustained voice, full level
            sum <= sum + 16'(wave_s);
            voice_phase[slot] <= voice_phase[slot] + voice_step[slot];
            idx <= idx + CNT_W'(1);
          end else begin
            voice_life[slot] <= life_dec;
            if (life_dec == 16'd0) begin
              idx <= idx + CNT_W'(1);
            end else if (life_dec < release_length) begin
              // inside the release ramp, scale by life / release_length
              w_neg    <= wave_s < 0;
              w_mag    <= 13'(wave_s < 0 ? -wave_s : wave_s);
              life_cur <= life_dec;
            end else begin
              sum <= sum + 16'(wave_s);
              voice_phase[slot] <= voice_phase[slot] + voice_step[slot];
              idx <= idx + CNT_W'(1);
            end
          end
        end
      end
      ST_MUL: begin
        prod    <= PROD_W'(w_mag) * PROD_W'(life_cur);
        div_cnt <= '0;
        rem     <= '0;
        quot    <= '0;
      end
      ST_DIV: begin
        if (div_cnt == 4'(QUOT_BITS + 1)) begin
          sum <= sum + 16'(scaled);
          voice_phase[slot] <= voice_phase[slot] + voice_step[slot];
          idx <= idx + CNT_W'(1);
        end else if (div_cnt == 4'd0) begin
          // load the high part; quotient is known to fit in 13 bits
          rem     <= prod[PROD_W-1 -: 16];
          prod    <= {prod[QUOT_BITS-1:0], 16'd0};
          div_cnt <= div_cnt + 4'd1;
          quot    <= '0;
        end else begin
          if (!div_diff[16]) begin
            rem  <= div_diff[15:0];
            quot <= {quot[QUOT_BITS-2:0], 1'b1};
          end else begin
            rem  <= div_trial[15:0];
            quot <= {quot[QUOT_BITS-2:0], 1'b0};
          end
          prod    <= {prod[PROD_W-2:0], 1'b0};
          div_cnt <= div_cnt + 4'd1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) sample <= sum;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
